FILE: rtl/lwi_pkg.sv
// lwi_pkg: shared types and constants for the Legendre weight interpolator.
// No dependencies; used by every module under rtl/.
package lwi_pkg;

    localparam int MAX_BINS_DEF        = 16;
    localparam int MAX_TERMS_DEF       = 8;
    localparam int COEFF_FRAC_BITS_DEF = 20;

    localparam int BINS_W    = 5;
    localparam int TERMS_W   = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BINS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TERMS = 1'd1;

    localparam int BIN_W  = 4;
    localparam int TERM_W = 3;
    localparam int COEF_W = 32;
    localparam int E_W    = 20;
    localparam int X_W    = 16;
    localparam int W_W    = 41;
    localparam int P_W    = 18;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    localparam int OFS_BIN  = 0;
    localparam int OFS_TERM = OFS_BIN + BIN_W;
    localparam int OFS_COEF = OFS_TERM + TERM_W;
    localparam int OFS_E    = OFS_COEF + COEF_W;
    localparam int OFS_X    = OFS_E + E_W;

    localparam logic signed [X_W-1:0] X_ONE  = 16'sd16384;
    localparam logic signed [X_W-1:0] X_MONE = -16'sd16384;
    localparam logic signed [P_W-1:0] P_ONE  = 18'sd16384;

    localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
    localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

    localparam int Q_DEPTH = 2;

    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = 7;
    localparam int DVS_W     = 21;

    typedef enum logic [1:0] {
        OP_LOAD_COEF = 2'd0,
        OP_LOAD_CTR  = 2'd1,
        OP_EVAL      = 2'd2
    } op_t;

    typedef struct packed {
        op_t                      kind;
        logic [BIN_W-1:0]         bin;
        logic [TERM_W-1:0]        term;
        logic signed [COEF_W-1:0] coef;
        logic [E_W-1:0]           energy;
        logic signed [X_W-1:0]    cosv;
    } req_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] bits;
        logic [DIV_W-1:0]     dividend;
        logic [DVS_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

endpackage

FILE: rtl/legendre_weight_interpolator.sv
// legendre_weight_interpolator: top level; config registers, front end,
// request queue, evaluation back end and shared divider.
// Depends on lwi_pkg, lwi_front, lwi_fifo, lwi_div, lwi_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  s_       | s_tvalid/s_tready  | tdata bin,term,coef,energy,cos; tuser op
//  m_       | m_tvalid/m_tready  | tdata weight; tuser saturated,zero_span
//  cfg_     | cfg_we             | cfg_index, cfg_wdata
//
// Loads are written to the tables as the back end pops them in its idle
// state. An evaluate request runs a bin search (k bins compared, k <= nb),
// then per bin a series of nt terms with nt - 2 recurrence divides, then a
// shift-add multiply, a divide and the output; it skips to the output when
// the two centres are equal. The restoring divider takes most of the time.
// Reset is synchronous, active low; tables are not cleared. The two-entry
// queue and the output register let input and output stall independently.
module legendre_weight_interpolator #(
    parameter int MAX_BINS        = lwi_pkg::MAX_BINS_DEF,
    parameter int MAX_TERMS       = lwi_pkg::MAX_TERMS_DEF,
    parameter int COEFF_FRAC_BITS = lwi_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lwi_pkg::S_TDATA_W-1:0]   s_tdata,  // bin, term, coef, energy, cos_theta
    input  logic [lwi_pkg::S_TUSER_W-1:0]   s_tuser,  // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lwi_pkg::M_TDATA_W-1:0]   m_tdata,  // weight
    output logic [lwi_pkg::M_TUSER_W-1:0]   m_tuser,  // saturated, zero_span
    input  logic                            cfg_we,
    input  logic [lwi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lwi_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int MDW = lwi_pkg::M_TDATA_W;

    logic [lwi_pkg::BINS_W-1:0]  bins_reg;
    logic [lwi_pkg::TERMS_W-1:0] terms_reg;

    logic                  q_push, q_full, q_pop, q_empty;
    lwi_pkg::req_t         q_din, q_dout;
    lwi_pkg::div_req_t     div_req;
    lwi_pkg::div_rsp_t     div_rsp;
    logic signed [lwi_pkg::W_W-1:0] weight;
    logic                  sat, zs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_reg  <= lwi_pkg::BINS_W'(2);
            terms_reg <= lwi_pkg::TERMS_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                lwi_pkg::REG_BINS:  bins_reg  <= cfg_wdata[lwi_pkg::BINS_W-1:0];
                lwi_pkg::REG_TERMS: terms_reg <= cfg_wdata[lwi_pkg::TERMS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lwi_front #(
        .MAX_BINS  (MAX_BINS),
        .MAX_TERMS (MAX_TERMS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_din    (q_din)
    );

    lwi_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    lwi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    lwi_back #(
        .MAX_BINS        (MAX_BINS),
        .MAX_TERMS       (MAX_TERMS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bins_in_use  (bins_reg),
        .terms_in_use (terms_reg),
        .q_valid      (!q_empty),
        .q_data       (q_dout),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_weight     (weight),
        .m_saturated  (sat),
        .m_zero_span  (zs)
    );

    assign m_tdata = MDW'($unsigned(weight));
    assign m_tuser = {zs, sat};

endmodule

FILE: rtl/lwi_front.sv
// lwi_front: accepts input requests, decodes the op, drops unused codes and
// out-of-range loads, clamps the cosine. Depends on lwi_pkg.
module lwi_front #(
    parameter int MAX_BINS  = lwi_pkg::MAX_BINS_DEF,
    parameter int MAX_TERMS = lwi_pkg::MAX_TERMS_DEF
) (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lwi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [lwi_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            q_full,
    output logic                            q_push,
    output lwi_pkg::req_t                   q_din
);

    logic                              keep;
    logic [lwi_pkg::BIN_W-1:0]         bin;
    logic [lwi_pkg::TERM_W-1:0]        term;
    logic signed [lwi_pkg::X_W-1:0]    xin;

    assign bin  = s_tdata[lwi_pkg::OFS_BIN +: lwi_pkg::BIN_W];
    assign term = s_tdata[lwi_pkg::OFS_TERM +: lwi_pkg::TERM_W];
    assign xin  = $signed(s_tdata[lwi_pkg::OFS_X +: lwi_pkg::X_W]);

    always_comb begin
        keep       = 1'b0;
        q_din.kind = lwi_pkg::OP_EVAL;
        unique case (s_tuser)
            2'(lwi_pkg::OP_LOAD_COEF): begin
                q_din.kind = lwi_pkg::OP_LOAD_COEF;
                keep       = (int'(bin) < MAX_BINS) && (int'(term) < MAX_TERMS);
            end
            2'(lwi_pkg::OP_LOAD_CTR): begin
                q_din.kind = lwi_pkg::OP_LOAD_CTR;
                keep       = int'(bin) < MAX_BINS;
            end
            2'(lwi_pkg::OP_EVAL): begin
                q_din.kind = lwi_pkg::OP_EVAL;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        q_din.bin    = bin;
        q_din.term   = term;
        q_din.coef   = $signed(s_tdata[lwi_pkg::OFS_COEF +: lwi_pkg::COEF_W]);
        q_din.energy = s_tdata[lwi_pkg::OFS_E +: lwi_pkg::E_W];
        priority if (xin > lwi_pkg::X_ONE) begin
            q_din.cosv = lwi_pkg::X_ONE;
        end else if (xin < lwi_pkg::X_MONE) begin
            q_din.cosv = lwi_pkg::X_MONE;
        end else begin
            q_din.cosv = xin;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

endmodule

FILE: rtl/lwi_fifo.sv
// lwi_fifo: short request queue between front and back end.
// Depends on lwi_pkg (req_t, Q_DEPTH).
module lwi_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lwi_pkg::req_t din,
    output logic          full,
    input  logic          pop,
    output lwi_pkg::req_t dout,
    output logic          empty
);

    localparam int PW = (lwi_pkg::Q_DEPTH > 1) ? $clog2(lwi_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(lwi_pkg::Q_DEPTH + 1);

    lwi_pkg::req_t  mem_reg [lwi_pkg::Q_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;

    assign full  = (int'(cnt_reg) == lwi_pkg::Q_DEPTH);
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= din;
                wr_ptr_reg <= (int'(wr_ptr_reg) == lwi_pkg::Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == lwi_pkg::Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/lwi_div.sv
// lwi_div: restoring divider, one quotient bit per cycle over a preshifted
// dividend. Depends on lwi_pkg (div_req_t, div_rsp_t).
module lwi_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  lwi_pkg::div_req_t req,
    output lwi_pkg::div_rsp_t rsp
);

    logic                          busy_reg, done_reg;
    logic [lwi_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [lwi_pkg::DVS_W-1:0]     rem_reg, dvs_reg;
    logic [lwi_pkg::DIV_W-1:0]     dq_reg;
    logic [lwi_pkg::DVS_W:0]       trial;
    logic                          ge;
    logic [lwi_pkg::DVS_W:0]       rem_next;

    always_comb begin
        trial    = {rem_reg, dq_reg[lwi_pkg::DIV_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? (trial - {1'b0, dvs_reg}) : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.bits;
                rem_reg  <= '0;
                dq_reg   <= req.dividend;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next[lwi_pkg::DVS_W-1:0];
                dq_reg  <= {dq_reg[lwi_pkg::DIV_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lwi_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = dq_reg;

endmodule

FILE: rtl/lwi_back.sv
// lwi_back: table storage and evaluation sequencer (bin search, Legendre
// series, interpolation). Depends on lwi_pkg; drives lwi_div through ports.
module lwi_back #(
    parameter int MAX_BINS        = lwi_pkg::MAX_BINS_DEF,
    parameter int MAX_TERMS       = lwi_pkg::MAX_TERMS_DEF,
    parameter int COEFF_FRAC_BITS = lwi_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lwi_pkg::BINS_W-1:0]    bins_in_use,
    input  logic [lwi_pkg::TERMS_W-1:0]   terms_in_use,
    input  logic                          q_valid,
    input  lwi_pkg::req_t                 q_data,
    output logic                          q_pop,
    output lwi_pkg::div_req_t             div_req,
    input  lwi_pkg::div_rsp_t             div_rsp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [lwi_pkg::W_W-1:0] m_weight,
    output logic                          m_saturated,
    output logic                          m_zero_span
);

    localparam int BW    = $clog2(MAX_BINS);
    localparam int NBW   = $clog2(MAX_BINS + 1);
    localparam int NTW   = $clog2(MAX_TERMS + 1);
    localparam int CAW   = $clog2(MAX_BINS * MAX_TERMS);
    localparam int PR_W  = lwi_pkg::COEF_W + lwi_pkg::P_W;
    localparam int SUM_W = PR_W + 6;
    localparam int SHIFT = COEFF_FRAC_BITS - 6;
    localparam int T1_W  = lwi_pkg::X_W + 6;
    localparam int T2_W  = T1_W + lwi_pkg::P_W;
    localparam int NUM_W = T2_W + 1;
    localparam int QP_W  = NUM_W - 14;
    localparam int D_W   = lwi_pkg::W_W + 1;
    localparam int SP_W  = lwi_pkg::E_W + 1;
    localparam int AC_W  = lwi_pkg::DIV_W - 1;
    localparam int MC_W  = $clog2(SP_W + 1);
    localparam int WS_W  = lwi_pkg::DIV_W + 1;

    localparam logic signed [SUM_W-1:0] RND  = SUM_W'((64'd1 << SHIFT) - 64'd1);
    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'(lwi_pkg::W_MAX);
    localparam logic signed [SUM_W-1:0] SMIN = SUM_W'(lwi_pkg::W_MIN);
    localparam logic signed [WS_W-1:0]  WMAX = WS_W'(lwi_pkg::W_MAX);
    localparam logic signed [WS_W-1:0]  WMIN = WS_W'(lwi_pkg::W_MIN);

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH, S_CMP, S_RDHI, S_RDLO, S_SPAN, S_CRD, S_CMUL, S_CACC,
        S_R1, S_R2, S_R3, S_RDIV, S_FIN, S_MSET, S_MUL, S_IDIV, S_IWAIT, S_OUT
    } state_t;

    state_t state_reg;

    logic signed [lwi_pkg::COEF_W-1:0] coef_mem [MAX_BINS * MAX_TERMS];
    logic [lwi_pkg::E_W-1:0]           ctr_mem  [MAX_BINS];
    logic signed [lwi_pkg::COEF_W-1:0] coef_q;
    logic [lwi_pkg::E_W-1:0]           ctr_q;
    logic [CAW-1:0]                    coef_waddr, coef_raddr;
    logic [BW-1:0]                     ctr_raddr;

    logic [NBW-1:0] nb, idx_reg, hi_reg, lo, sbin;
    logic [NTW-1:0] nt, l_reg;
    logic           on_hi_reg;

    logic [lwi_pkg::E_W-1:0]          e_reg, ehi_reg, elo_reg;
    logic signed [lwi_pkg::X_W-1:0]   x_reg;
    logic signed [SP_W-1:0]           span_reg;
    logic signed [lwi_pkg::P_W-1:0]   p_reg, pm_reg;
    logic signed [PR_W-1:0]           prod_reg;
    logic signed [SUM_W-1:0]          sum_reg;
    logic signed [T1_W-1:0]           t1_reg;
    logic signed [T2_W-1:0]           t2_reg;
    logic                             neg_reg;
    logic signed [lwi_pkg::W_W-1:0]   nlo_reg, nhi_reg;
    logic                             sat_reg;
    logic [AC_W-1:0]                  acc_reg, mcand_reg;
    logic [SP_W-1:0]                  mplier_reg;
    logic [MC_W-1:0]                  mcnt_reg;
    logic                             isign_reg;
    lwi_pkg::div_req_t                div_req_reg;

    logic                             out_valid_reg, out_sat_reg, out_zs_reg;
    logic signed [lwi_pkg::W_W-1:0]   out_w_reg;
    logic signed [lwi_pkg::W_W-1:0]   res_w_reg;
    logic                             res_sat_reg, res_zs_reg;

    // clamped register values
    always_comb begin
        if (int'(bins_in_use) < 2) begin
            nb = NBW'(2);
        end else if (int'(bins_in_use) > MAX_BINS) begin
            nb = NBW'(MAX_BINS);
        end else begin
            nb = NBW'(bins_in_use);
        end
        if (terms_in_use == '0) begin
            nt = NTW'(1);
        end else if (int'(terms_in_use) > MAX_TERMS) begin
            nt = NTW'(MAX_TERMS);
        end else begin
            nt = NTW'(terms_in_use);
        end
    end

    assign lo   = hi_reg - 1'b1;
    assign sbin = on_hi_reg ? hi_reg : lo;

    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign coef_waddr = CAW'(int'(q_data.bin) * MAX_TERMS + int'(q_data.term));
    assign coef_raddr = CAW'(int'(sbin) * MAX_TERMS + int'(l_reg));

    always_comb begin
        unique case (state_reg)
            S_RDHI:  ctr_raddr = hi_reg[BW-1:0];
            S_RDLO:  ctr_raddr = lo[BW-1:0];
            default: ctr_raddr = idx_reg[BW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_data.kind == lwi_pkg::OP_LOAD_COEF) begin
            coef_mem[coef_waddr] <= q_data.coef;
        end
        if (q_pop && q_data.kind == lwi_pkg::OP_LOAD_CTR) begin
            ctr_mem[BW'(q_data.bin)] <= q_data.energy;
        end
        coef_q <= coef_mem[coef_raddr];
        ctr_q  <= ctr_mem[ctr_raddr];
    end

    // series scaling to Q.20 with truncation toward zero, then clip
    logic signed [SUM_W-1:0]         sum_adj, sum_sh;
    logic signed [lwi_pkg::W_W-1:0]  ser_val;
    logic                            ser_sat;

    always_comb begin
        sum_adj = sum_reg + (sum_reg[SUM_W-1] ? RND : '0);
        sum_sh  = sum_adj >>> SHIFT;
        ser_sat = 1'b0;
        priority if (sum_sh > SMAX) begin
            ser_val = lwi_pkg::W_MAX;
            ser_sat = 1'b1;
        end else if (sum_sh < SMIN) begin
            ser_val = lwi_pkg::W_MIN;
            ser_sat = 1'b1;
        end else begin
            ser_val = sum_sh[lwi_pkg::W_W-1:0];
        end
    end

    // recurrence numerator
    logic signed [5:0]       oddk;
    logic signed [NUM_W-1:0] lpm, num;
    logic [NUM_W-1:0]        num_mag;

    always_comb begin
        oddk    = $signed(6'({l_reg, 1'b1}));
        lpm     = NUM_W'($signed({1'b0, l_reg})) * NUM_W'(pm_reg);
        num     = NUM_W'(t2_reg) - (lpm <<< 14);
        num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    end

    // interpolation terms
    logic signed [D_W-1:0]   dn;
    logic signed [SP_W-1:0]  de;
    logic signed [lwi_pkg::DIV_W-1:0] qs;
    logic signed [WS_W-1:0]  wsum;

    always_comb begin
        dn   = D_W'(nhi_reg) - D_W'(nlo_reg);
        de   = $signed({1'b0, e_reg}) - $signed({1'b0, elo_reg});
        qs   = isign_reg ? -$signed({1'b0, div_rsp.quo[AC_W-1:0]})
                         : $signed({1'b0, div_rsp.quo[AC_W-1:0]});
        wsum = WS_W'(nlo_reg) + WS_W'(qs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            div_req_reg.start <= 1'b0;
        end else begin
            div_req_reg.start <= 1'b0;
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_data.kind == lwi_pkg::OP_EVAL) begin
                        e_reg     <= q_data.energy;
                        x_reg     <= q_data.cosv;
                        idx_reg   <= '0;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    if (ctr_q > e_reg) begin
                        hi_reg    <= (idx_reg == '0) ? NBW'(1) : idx_reg;
                        state_reg <= S_RDHI;
                    end else if (idx_reg == nb - 1'b1) begin
                        hi_reg    <= nb - 1'b1;
                        state_reg <= S_RDHI;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SRCH;
                    end
                end
                S_RDHI: begin
                    state_reg <= S_RDLO;
                end
                S_RDLO: begin
                    ehi_reg   <= ctr_q;
                    state_reg <= S_SPAN;
                end
                S_SPAN: begin
                    elo_reg  <= ctr_q;
                    span_reg <= $signed({1'b0, ehi_reg}) - $signed({1'b0, ctr_q});
                    if (ehi_reg == ctr_q) begin
                        res_w_reg   <= '0;
                        res_sat_reg <= 1'b0;
                        res_zs_reg  <= 1'b1;
                        state_reg   <= S_OUT;
                    end else begin
                        on_hi_reg <= 1'b0;
                        l_reg     <= '0;
                        p_reg     <= lwi_pkg::P_ONE;
                        pm_reg    <= '0;
                        sum_reg   <= '0;
                        sat_reg   <= 1'b0;
                        state_reg <= S_CRD;
                    end
                end
                S_CRD: begin
                    state_reg <= S_CMUL;
                end
                S_CMUL: begin
                    prod_reg  <= PR_W'(coef_q) * PR_W'(p_reg);
                    state_reg <= S_CACC;
                end
                S_CACC: begin
                    sum_reg <= sum_reg + SUM_W'(prod_reg);
                    if (l_reg == nt - 1'b1) begin
                        state_reg <= S_FIN;
                    end else if (l_reg == '0) begin
                        pm_reg    <= p_reg;
                        p_reg     <= lwi_pkg::P_W'(x_reg);
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= S_CRD;
                    end else begin
                        state_reg <= S_R1;
                    end
                end
                S_R1: begin
                    t1_reg    <= T1_W'(x_reg) * T1_W'(oddk);
                    state_reg <= S_R2;
                end
                S_R2: begin
                    t2_reg    <= T2_W'(t1_reg) * T2_W'(p_reg);
                    state_reg <= S_R3;
                end
                S_R3: begin
                    neg_reg              <= num[NUM_W-1];
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.bits     <= lwi_pkg::DIV_CNT_W'(QP_W);
                    div_req_reg.dividend <= {num_mag[NUM_W-1:14],
                                             (lwi_pkg::DIV_W - QP_W)'(0)};
                    div_req_reg.divisor  <= lwi_pkg::DVS_W'(l_reg) + 1'b1;
                    state_reg            <= S_RDIV;
                end
                S_RDIV: begin
                    if (div_rsp.done) begin
                        pm_reg    <= p_reg;
                        p_reg     <= neg_reg ? -lwi_pkg::P_W'(div_rsp.quo[QP_W-1:0])
                                             : lwi_pkg::P_W'(div_rsp.quo[QP_W-1:0]);
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= S_CRD;
                    end
                end
                S_FIN: begin
                    sat_reg <= sat_reg | ser_sat;
                    if (!on_hi_reg) begin
                        nlo_reg   <= ser_val;
                        on_hi_reg <= 1'b1;
                        l_reg     <= '0;
                        p_reg     <= lwi_pkg::P_ONE;
                        pm_reg    <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_CRD;
                    end else begin
                        nhi_reg   <= ser_val;
                        state_reg <= S_MSET;
                    end
                end
                S_MSET: begin
                    mcand_reg  <= dn[D_W-1] ? AC_W'(-dn) : AC_W'(dn);
                    mplier_reg <= de[SP_W-1] ? SP_W'(-de) : SP_W'(de);
                    acc_reg    <= '0;
                    mcnt_reg   <= MC_W'(SP_W);
                    isign_reg  <= dn[D_W-1] ^ de[SP_W-1] ^ span_reg[SP_W-1];
                    state_reg  <= S_MUL;
                end
                S_MUL: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    mcnt_reg   <= mcnt_reg - 1'b1;
                    if (mcnt_reg == MC_W'(1)) begin
                        state_reg <= S_IDIV;
                    end
                end
                S_IDIV: begin
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.bits     <= lwi_pkg::DIV_CNT_W'(AC_W);
                    div_req_reg.dividend <= {acc_reg, 1'b0};
                    div_req_reg.divisor  <= span_reg[SP_W-1] ? lwi_pkg::DVS_W'(-span_reg)
                                                             : lwi_pkg::DVS_W'(span_reg);
                    state_reg            <= S_IWAIT;
                end
                S_IWAIT: begin
                    if (div_rsp.done) begin
                        res_zs_reg <= 1'b0;
                        priority if (wsum > WMAX) begin
                            res_w_reg   <= lwi_pkg::W_MAX;
                            res_sat_reg <= 1'b1;
                        end else if (wsum < WMIN) begin
                            res_w_reg   <= lwi_pkg::W_MIN;
                            res_sat_reg <= 1'b1;
                        end else begin
                            res_w_reg   <= wsum[lwi_pkg::W_W-1:0];
                            res_sat_reg <= sat_reg;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_w_reg     <= res_w_reg;
                        out_sat_reg   <= res_sat_reg;
                        out_zs_reg    <= res_zs_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign div_req     = div_req_reg;
    assign m_valid     = out_valid_reg;
    assign m_weight    = out_w_reg;
    assign m_saturated = out_sat_reg;
    assign m_zero_span = out_zs_reg;

    a_zero_span_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_zs_reg) |-> (out_w_reg == '0 && !out_sat_reg))
        else $error("zero span result carries a weight");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_RDIV || state_reg == S_IWAIT))
        else $error("divider finished outside a wait state");

    a_bin_pair_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RDLO) |-> (hi_reg != '0 && hi_reg < nb))
        else $error("upper bin out of range");

endmodule
